>>> hdl/pesd_pkg.sv
// ----------------------------------------------------------------------------
// pesd_pkg
// shared types and constants for the encoder speed and distance block
// ----------------------------------------------------------------------------
package pesd_pkg;

  localparam int FracBits = 16;

  // command codes
  localparam logic [1:0] CMD_PULSE = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_PPR    = 3'd1;
  localparam logic [2:0] REG_MULT   = 3'd2;
  localparam logic [2:0] REG_FREQ   = 3'd3;
  localparam logic [2:0] REG_DPP    = 3'd4;

  localparam logic [1:0] MOTION_STOP = 2'd0;
  localparam logic [1:0] MOTION_FWD  = 2'd1;
  localparam logic [1:0] MOTION_REV  = 2'd2;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;

  // controller to datapath commands
  typedef struct packed {
    logic do_pulse;   // apply a pulse item
    logic do_set;     // load position
    logic tick_start; // latch tick operands
    logic mul_step;   // one partial product step
    logic div_init;   // set up the divider
    logic div_step;   // one quotient bit
    logic tick_end;   // commit speed and distance
  } pesd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic mul_done;
    logic div_done;
  } pesd_sts_t;

endpackage

>>> hdl/pesd_ctrl.sv
// ----------------------------------------------------------------------------
// pesd_ctrl
// controller state machine: sequences items through the datapath
// ----------------------------------------------------------------------------
module pesd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic               enable,
  output logic               out_valid,
  input  logic               out_stall,
  output pesd_pkg::pesd_cmd_t cmd,
  input  pesd_pkg::pesd_sts_t sts
);
  import pesd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIVI = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  // items are taken only in idle, the result waits in S_OUT
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_OUT;
          if (in_command == CMD_PULSE && enable) begin
            cmd.do_pulse = 1'b1;
          end else if (in_command == CMD_TICK && enable) begin
            cmd.tick_start = 1'b1;
            state_nxt = S_MUL;
          end else if (in_command == CMD_SET) begin
            cmd.do_set = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) begin
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        cmd.tick_end = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/pesd_dp.sv
// ----------------------------------------------------------------------------
// pesd_dp
// datapath: position, window, multi-cycle speed division and distance
// ----------------------------------------------------------------------------
module pesd_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  pesd_pkg::pesd_cmd_t cmd,
  output pesd_pkg::pesd_sts_t sts,
  input  logic                in_dir_level,
  input  logic [31:0]         in_timestamp,
  input  logic signed [63:0]  in_counter_value,
  input  logic [15:0]         ppr,
  input  logic [7:0]          mult,
  input  logic [31:0]         freq,
  input  logic [31:0]         dpp,
  output logic signed [31:0]  out_speed_rpm,
  output logic signed [31:0]  out_distance,
  output logic signed [63:0]  out_position,
  output logic [1:0]          out_motion
);
  import pesd_pkg::*;

  // architectural state
  logic [63:0] pos_r;
  logic        fwd_r;
  logic        wopen_r;
  logic [30:0] wcnt_r;
  logic [31:0] wfirst_r, wlast_r;
  logic [63:0] last_pos_r;
  logic [31:0] dist_r;
  logic [31:0] speed_r;

  // tick working registers
  logic        valid_r;    // speed is to be computed
  logic [30:0] intv_r;     // n-1
  logic [31:0] elap_r;
  logic [1:0]  mstep_r;
  logic [62:0] fi_r;       // freq*intervals
  logic [47:0] num_r;      // 60*freq*intervals
  logic        novf_r;     // numerator overflow
  logic [55:0] den_r;      // ppr*mult*elapsed
  logic [23:0] pm_r;       // ppr*mult
  logic [63:0] dmag_r;
  logic        dneg_r;
  logic [31:0] pmag_r;
  logic        pneg_r;
  logic [65:0] dprod_r;
  logic [63:0] dividend_r;
  logic [63:0] quot_r;
  logic [56:0] rem_r;
  logic [6:0]  dcnt_r;

  logic [63:0] delta;
  logic [68:0] fnum;
  logic [56:0] rem_sh;
  logic [56:0] rem_sub;

  assign delta  = pos_r - last_pos_r;
  // times 60 as 64 - 4
  assign fnum   = {fi_r, 6'd0} - {4'd0, fi_r, 2'd0};
  assign sts.mul_done = (mstep_r == 2'd3);
  assign sts.div_done = (dcnt_r == 7'd63);
  assign rem_sh  = {rem_r[55:0], dividend_r[63]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  // multi-step numerator, denominator and distance products, then the restoring division
  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      mstep_r <= 2'd0;
      intv_r  <= wcnt_r - 31'd1;
      elap_r  <= wlast_r - wfirst_r;
      valid_r <= wopen_r && (wcnt_r > 31'd1) && (wlast_r != wfirst_r);
      pm_r    <= {8'd0, ppr} * {16'd0, mult};
      dneg_r  <= delta[63];
      dmag_r  <= delta[63] ? (64'd0 - delta) : delta;
      pneg_r  <= dpp[31];
      pmag_r  <= dpp[31] ? (32'd0 - dpp) : dpp;
    end else if (cmd.mul_step) begin
      mstep_r <= mstep_r + 2'd1;
      case (mstep_r)
        2'd0: begin
          // 32 x 31 product, scaled by 60 in the next step
          fi_r  <= 63'({31'd0, freq} * {32'd0, intv_r});
          den_r <= 56'({32'd0, pm_r} * {24'd0, elap_r});
        end
        2'd1: begin
          // overflow past 48 bits
          novf_r  <= |fnum[68:48];
          num_r   <= fnum[47:0];
          dprod_r <= 66'({dmag_r[33:0]} * {2'd0, pmag_r});
        end
        default: begin
          dividend_r <= {num_r, 16'd0};
        end
      endcase
    end else if (cmd.div_init) begin
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      // restoring division, one quotient bit a cycle
      dcnt_r     <= dcnt_r + 7'd1;
      dividend_r <= {dividend_r[62:0], 1'b0};
      if (!rem_sub[56]) begin
        rem_r  <= rem_sub;
        quot_r <= {quot_r[62:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        quot_r <= {quot_r[62:0], 1'b0};
      end
    end
  end

  // architectural updates
  logic [31:0] mag;
  logic [31:0] spd;
  logic        dsat;
  logic signed [34:0] dsum;
  logic signed [34:0] dterm;
  always_comb begin
    if (novf_r || (quot_r > {32'd0, SAT_MAX})) begin
      mag = SAT_MAX;
    end else begin
      mag = quot_r[31:0];
    end
    if (!valid_r || den_r == 56'd0) begin
      spd = '0;
    end else begin
      spd = fwd_r ? mag : (32'd0 - mag);
    end
    dsat  = (dmag_r >= 64'h2_0000_0000) || (dprod_r > 66'h2_0000_0000);
    dterm = dneg_r != pneg_r ? -$signed({1'b0, dprod_r[33:0]})
                             : $signed({1'b0, dprod_r[33:0]});
    dsum  = $signed({{3{dist_r[31]}}, dist_r}) + dterm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; fwd_r <= 1'b1; wopen_r <= 1'b0; wcnt_r <= '0;
      wfirst_r <= '0; wlast_r <= '0; last_pos_r <= '0;
      dist_r <= '0; speed_r <= '0;
    end else if (cmd.do_pulse) begin
      fwd_r <= in_dir_level;
      pos_r <= in_dir_level ? pos_r + 64'd1 : pos_r - 64'd1;
      if (!wopen_r) begin
        wfirst_r <= in_timestamp;
        wcnt_r   <= 31'd1;
        wopen_r  <= 1'b1;
      end else if (wcnt_r != '1) begin
        wcnt_r <= wcnt_r + 31'd1;
      end
      wlast_r <= in_timestamp;
    end else if (cmd.do_set) begin
      pos_r      <= in_counter_value;
      last_pos_r <= in_counter_value;
      dist_r     <= '0;
    end else if (cmd.tick_end) begin
      wopen_r    <= 1'b0;
      wcnt_r     <= '0;
      speed_r    <= spd;
      last_pos_r <= pos_r;
      if (dmag_r != 64'd0 && pmag_r != 32'd0) begin
        if (dsat) begin
          dist_r <= (dneg_r != pneg_r) ? 32'h8000_0000 : SAT_MAX;
        end else if (dsum > 35'sd2147483647) begin
          dist_r <= SAT_MAX;
        end else if (dsum < -35'sd2147483648) begin
          dist_r <= 32'h8000_0000;
        end else begin
          dist_r <= dsum[31:0];
        end
      end
    end
  end

  assign out_speed_rpm = speed_r;
  assign out_distance  = dist_r;
  assign out_position  = pos_r;
  assign out_motion    = (speed_r == 32'd0) ? MOTION_STOP :
                         (speed_r[31] ? MOTION_REV : MOTION_FWD);

endmodule

>>> hdl/pesd_regs.sv
// ----------------------------------------------------------------------------
// pesd_regs
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module pesd_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        enable,
  output logic [15:0] ppr,
  output logic [7:0]  mult,
  output logic [31:0] freq,
  output logic [31:0] dpp
);
  import pesd_pkg::*;

  logic        en_r;
  logic [15:0] ppr_r;
  logic [7:0]  mult_r;
  logic [31:0] freq_r, dpp_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0; ppr_r <= 16'd1; mult_r <= 8'd1; freq_r <= 32'd1; dpp_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_ENABLE: en_r   <= pwdata[0];
        REG_PPR:    ppr_r  <= pwdata[15:0];
        REG_MULT:   mult_r <= pwdata[7:0];
        REG_FREQ:   freq_r <= pwdata;
        REG_DPP:    dpp_r  <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[4:2])
      REG_ENABLE: prdata = {31'd0, en_r};
      REG_PPR:    prdata = {16'd0, ppr_r};
      REG_MULT:   prdata = {24'd0, mult_r};
      REG_FREQ:   prdata = freq_r;
      REG_DPP:    prdata = dpp_r;
      default:    prdata = '0;
    endcase
  end

  assign enable = en_r;
  assign ppr    = ppr_r;
  assign mult   = mult_r;
  assign freq   = freq_r;
  assign dpp    = dpp_r;

endmodule

>>> hdl/pulse_encoder_speed_distance_top.sv
// ----------------------------------------------------------------------------
// pulse_encoder_speed_distance_top
// encoder position, period speed and distance measurement
// ----------------------------------------------------------------------------
// One item is handled at a time. Pulse, set counter, unknown and disabled items
// present their result in the cycle after acceptance; a sample tick presents it
// after four operand multiply steps, a divider set-up step, the 64 quotient-bit
// steps of the restoring divider that forms the Q16.16 speed, and a commit step.
// The result is held until taken; the next item is then taken from the following
// cycle.
module pulse_encoder_speed_distance_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic               in_dir_level,
  input  logic [31:0]        in_timestamp,
  input  logic signed [63:0] in_counter_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_speed_rpm,
  output logic signed [31:0] out_distance,
  output logic signed [63:0] out_position,
  output logic [1:0]         out_motion,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pesd_pkg::*;

  pesd_cmd_t   cmd;
  pesd_sts_t   sts;
  logic        enable;
  logic [15:0] ppr;
  logic [7:0]  mult;
  logic [31:0] freq, dpp;

  pesd_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .enable, .ppr, .mult, .freq, .dpp
  );

  pesd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .enable,
    .out_valid, .out_stall, .cmd, .sts
  );

  pesd_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_dir_level, .in_timestamp, .in_counter_value,
    .ppr, .mult, .freq, .dpp, .out_speed_rpm, .out_distance, .out_position,
    .out_motion
  );

endmodule

>>> hdl/pesd_checker.sv
// ----------------------------------------------------------------------------
// pesd_checker
// port-level checks of the encoder block
// ----------------------------------------------------------------------------
module pesd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_speed_rpm,
  input logic [1:0]         out_motion,
  input logic               pready
);
  import pesd_pkg::*;

  // one item at a time: no input taken while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("item taken while result pending");

  // motion is stop exactly when the speed is zero
  a_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_speed_rpm == 0) == (out_motion == MOTION_STOP)))
    else $error("motion disagrees with speed");

  // a held result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_speed_rpm))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) pready) else $error("pready low");

endmodule

bind pulse_encoder_speed_distance_top pesd_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall,
  .out_speed_rpm, .out_motion, .pready
);

>>> bench/pulse_encoder_speed_distance_top_test.sv
// ----------------------------------------------------------------------------
// pulse_encoder_speed_distance_top_test
// checks position, speed, distance and motion results item by item against an
// in-bench predictor, over directed and random items with random idling and stalls
// ----------------------------------------------------------------------------
module pulse_encoder_speed_distance_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pesd_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_command;
  logic               in_dir_level;
  logic [31:0]        in_timestamp;
  logic signed [63:0] in_counter_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_speed_rpm;
  logic signed [31:0] out_distance;
  logic signed [63:0] out_position;
  logic [1:0]         out_motion;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  pulse_encoder_speed_distance_top DUT (.*);

  // expected result of one item
  typedef struct packed {
    logic [31:0] speed;
    logic [31:0] dist_val;
    logic [63:0] pos;
    logic [1:0]  motion;
  } enc_result_t;

  enc_result_t result_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // predictor configuration and state
  logic        en_r;
  logic [15:0] ppr_r;
  logic [7:0]  mult_r;
  logic [31:0] freq_r;
  logic [31:0] dpp_r;
  logic [63:0] pos_r;
  logic        fwd_r;
  logic        win_open;
  logic [31:0] win_cnt;
  logic [31:0] win_first;
  logic [31:0] win_last;
  logic [63:0] last_pos;
  logic signed [31:0] dist_r;
  logic signed [31:0] speed_r;

  // clock
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic logic [31:0] rpm_mag(logic [31:0] iv, logic [31:0] el);
    logic [63:0] f60;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] sc;
    f60 = 64'd60 * {32'd0, freq_r};
    den = ({48'd0, ppr_r} * {56'd0, mult_r}) * {32'd0, el};
    if (den == 0) return 32'd0;
    if (f60 > (64'hffff_ffff_ffff_ffff >> FracBits) / {32'd0, iv}) return SAT_MAX;
    num = f60 * {32'd0, iv};
    sc = (num << FracBits) / den;
    if (sc > {32'd0, SAT_MAX}) return SAT_MAX;
    return sc[31:0];
  endfunction

  // distance accumulation at a tick
  task automatic accumulate_distance();
    logic [63:0] d;
    logic [63:0] dmag;
    logic [63:0] pmag;
    logic [63:0] prod;
    logic        neg;
    logic signed [63:0] sum;
    d = pos_r - last_pos;
    dmag = d[63] ? -d : d;
    pmag = dpp_r[31] ? {32'd0, -dpp_r} : {32'd0, dpp_r};
    neg = d[63] != dpp_r[31];
    last_pos = pos_r;
    if (dmag == 0 || pmag == 0) return;
    prod = dmag * pmag;
    if (dmag >= 64'd1 << 33 || prod > 64'd1 << 33) begin
      dist_r = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      return;
    end
    sum = 64'(dist_r) + (neg ? -$signed(prod) : $signed(prod));
    if (sum > 64'sd2147483647) dist_r = 32'sh7fff_ffff;
    else if (sum < -64'sd2147483648) dist_r = 32'sh8000_0000;
    else dist_r = sum[31:0];
  endtask

  // predict the result of one item
  task automatic predict_item(logic [1:0] cmd, logic dir, logic [31:0] ts, logic [63:0] cv);
    logic [31:0] n;
    logic [31:0] e;
    logic [31:0] s;
    enc_result_t r;
    if (cmd == CMD_PULSE && en_r) begin
      fwd_r = dir;
      pos_r = dir ? pos_r + 64'd1 : pos_r - 64'd1;
      if (!win_open) begin
        win_first = ts;
        win_cnt = 32'd1;
        win_open = 1'b1;
      end else if (win_cnt < SAT_MAX) begin
        win_cnt++;
      end
      win_last = ts;
    end else if (cmd == CMD_TICK && en_r) begin
      n = win_open ? win_cnt : 32'd0;
      e = win_last - win_first;
      s = 32'd0;
      win_open = 1'b0;
      win_cnt = 32'd0;
      if (n > 1 && e > 0) begin
        s = rpm_mag(n - 32'd1, e);
        if (!fwd_r) s = -s;
      end
      speed_r = s;
      accumulate_distance();
    end else if (cmd == CMD_SET) begin
      pos_r = cv;
      last_pos = cv;
      dist_r = 32'sd0;
    end
    r.speed = speed_r;
    r.dist_val = dist_r;
    r.pos = pos_r;
    r.motion = speed_r == 0 ? MOTION_STOP : (speed_r > 0 ? MOTION_FWD : MOTION_REV);
    result_q.push_back(r);
  endtask

  // send one item and record its expected result; valid stays high after
  // acceptance until the next item or an idle cycle replaces it
  task automatic send_item(logic [1:0] cmd, logic dir, logic [31:0] ts, logic [63:0] cv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_dir_level <= dir;
    in_timestamp <= ts;
    in_counter_value <= cv;
    predict_item(cmd, dir, ts, cv);
    // stall is settled by the falling edge before the accepting edge
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // register write while idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_ENABLE: en_r = val[0];
      REG_PPR:    ppr_r = val[15:0];
      REG_MULT:   mult_r = val[7:0];
      REG_FREQ:   freq_r = val;
      REG_DPP:    dpp_r = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic configure(logic en, logic [15:0] ppr, logic [7:0] m, logic [31:0] f,
                           logic [31:0] dpp);
    wait_drained();
    write_reg(REG_ENABLE, {31'd0, en});
    write_reg(REG_PPR, {16'd0, ppr});
    write_reg(REG_MULT, {24'd0, m});
    write_reg(REG_FREQ, f);
    write_reg(REG_DPP, dpp);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    enc_result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result speed %h dist %h pos %h", $realtime,
                   out_speed_rpm, out_distance, out_position);
          errors++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_speed_rpm !== exp_r.speed) begin
            $display("%0t: speed expected %h actual %h", $realtime, exp_r.speed, out_speed_rpm);
            errors++;
          end
          if (out_distance !== exp_r.dist_val) begin
            $display("%0t: distance expected %h actual %h", $realtime, exp_r.dist_val,
                     out_distance);
            errors++;
          end
          if (out_position !== exp_r.pos) begin
            $display("%0t: position expected %h actual %h", $realtime, exp_r.pos,
                     out_position);
            errors++;
          end
          if (out_motion !== exp_r.motion) begin
            $display("%0t: motion expected %h actual %h", $realtime, exp_r.motion, out_motion);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // directed extremes and special cases
  task automatic test_directed();
    send_item(CMD_PULSE, 1'b1, 32'd5, 64'd0);   // disabled: ignored
    send_item(CMD_TICK, 1'b0, 32'd0, 64'd0);
    send_item(CMD_NOP, 1'b1, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_item(CMD_SET, 1'b0, 32'd0, 64'h7fff_ffff_ffff_ffff);
    configure(1'b1, 16'd1, 8'd1, 32'hffff_ffff, 32'h7fff_ffff);
    // position wrap and speed saturation
    send_item(CMD_PULSE, 1'b1, 32'hffff_fff0, 64'd0);
    send_item(CMD_PULSE, 1'b1, 32'h0000_0010, 64'd0);
    send_item(CMD_TICK, 1'b1, 32'd0, 64'd0);
    // one pulse only, then zero elapsed
    send_item(CMD_PULSE, 1'b0, 32'd7, 64'd0);
    send_item(CMD_TICK, 1'b0, 32'd0, 64'd0);
    send_item(CMD_PULSE, 1'b0, 32'd9, 64'd0);
    send_item(CMD_PULSE, 1'b0, 32'd9, 64'd0);
    send_item(CMD_TICK, 1'b0, 32'd0, 64'd0);
    send_item(CMD_SET, 1'b1, 32'd0, 64'h8000_0000_0000_0000);
    send_item(CMD_TICK, 1'b1, 32'd0, 64'd0);
    configure(1'b1, 16'd0, 8'd255, 32'd1, 32'h8000_0000);  // zero divisor
    send_item(CMD_PULSE, 1'b1, 32'd1, 64'd0);
    send_item(CMD_PULSE, 1'b1, 32'd100, 64'd0);
    send_item(CMD_TICK, 1'b1, 32'd0, 64'd0);
    configure(1'b1, 16'hffff, 8'd0, 32'd1, 32'h0001_0000);
    send_item(CMD_PULSE, 1'b0, 32'd1, 64'd0);
    send_item(CMD_PULSE, 1'b0, 32'd3, 64'd0);
    send_item(CMD_TICK, 1'b0, 32'd0, 64'd0);
  endtask

  // random windows of pulses under several settings
  task automatic test_random(int n_items);
    int sent;
    int k;
    int np;
    logic [31:0] ts;
    logic        dir;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(9);
      if (k < 7) begin
        np = $urandom_range(1, 8);
        ts = $urandom;
        dir = 1'($urandom_range(1));
        repeat (np) begin
          send_item(CMD_PULSE, ($urandom_range(9) == 0) ? ~dir : dir, ts, rand64());
          ts = ts + ($urandom_range(3) == 0 ? $urandom : $urandom_range(2000));
          sent++;
        end
        send_item(CMD_TICK, 1'($urandom_range(1)), $urandom, rand64());
      end else if (k == 7) begin
        send_item(CMD_SET, 1'($urandom_range(1)), $urandom,
                  $urandom_range(1) ? rand64() : 64'($signed($urandom_range(1000)) - 500));
      end else begin
        send_item(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom, rand64());
      end
      sent++;
    end
  endtask

  task automatic test_phase(int idle, int stall, int n_items);
    logic [7:0] m;
    wait_drained();
    send_idle_pct = idle;
    recv_stall_pct = stall;
    m = 8'($urandom_range(1, 255));
    configure($urandom_range(7) != 0, $urandom_range(1) ? 16'($urandom_range(1, 64)) :
              16'($urandom), $urandom_range(1) ? 8'd1 : m,
              $urandom_range(1) ? 32'($urandom_range(1, 1000000)) : $urandom,
              $urandom_range(1) ? 32'($signed($urandom_range(200000)) - 100000) : $urandom);
    test_random(n_items);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_command = CMD_PULSE; in_dir_level = 1'b0;
    in_timestamp = '0; in_counter_value = '0; out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    en_r = 1'b0; ppr_r = 16'd1; mult_r = 8'd1; freq_r = 32'd1; dpp_r = 32'd0;
    pos_r = '0; fwd_r = 1'b1; win_open = 1'b0; win_cnt = '0; win_first = '0;
    win_last = '0; last_pos = '0; dist_r = '0; speed_r = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_phase(0, 0, 70);
    test_phase(57, 0, 70);
    test_phase(0, 57, 70);
    test_phase(7, 7, 70);
    test_phase(0, 0, 70);
    test_phase(57, 57, 70);
    test_phase(7, 7, 70);
    test_phase(0, 0, 60);
    wait_drained();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
